>>> src/msgseg_pkg.sv
// ============================================================================
// msgseg_pkg: shared definitions of the message segmenter
// Sizing constants, field widths, the controller state type and the structs
// that pass between the controller, the serial divider and the emitter.
// ============================================================================
package msgseg_pkg;

    // Sizing of the packet format.
    localparam int MAX_PACKET_BYTES = 1024;
    localparam int HEADER_BYTES     = 8;
    localparam int MAX_PACKETS      = 64;
    localparam int CAPACITY         = MAX_PACKET_BYTES - HEADER_BYTES;

    // Fixed field widths of the ports.
    localparam int HOST_W   = 32;
    localparam int LEN_W    = 16;
    localparam int MSG_W    = 8;
    localparam int REMAIN_W = 6;
    localparam int PAY_W    = 10;
    localparam int PKT_W    = 11;

    // Derived internal widths.
    localparam int CAP_W  = $clog2(CAPACITY + 1);
    localparam int CNT_W  = $clog2(MAX_PACKETS + 1);
    localparam int LEFT_W = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
    localparam int NUM_W  = LEN_W + 1;
    localparam int DEN_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int STEP_W = $clog2(NUM_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_CHUNK,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic              valid;
        logic [LEN_W-1:0]  len;
        logic [CAP_W-1:0]  chunk;
        logic [LEFT_W-1:0] left;
        logic [MSG_W-1:0]  msg;
    } t_load;

endpackage

>>> src/msgseg_serdiv.sv
// ============================================================================
// msgseg_serdiv: bit-serial restoring divider
// Produces one quotient bit per cycle; the numerator shifts out of a shift
// register and the quotient shifts in, so only a narrow subtractor is used.
// ============================================================================
module msgseg_serdiv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  msgseg_pkg::t_div_req i_req,
    output msgseg_pkg::t_div_rsp o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [msgseg_pkg::STEP_W-1:0]   r_step;
    logic [msgseg_pkg::NUM_W-1:0]    r_num;
    logic [msgseg_pkg::NUM_W-1:0]    r_quo;
    logic [msgseg_pkg::DEN_W-1:0]    r_rem;
    logic [msgseg_pkg::DEN_W-1:0]    r_den;

    logic [msgseg_pkg::DEN_W:0]      w_part;
    logic [msgseg_pkg::DEN_W:0]      w_diff;
    logic                            w_ge;
    logic [msgseg_pkg::DEN_W-1:0]    n_rem;
    logic                            w_last;

    // The partial remainder stays below twice the divisor, so one compare
    // and subtract settles each quotient bit.
    assign w_part = {r_rem, r_num[msgseg_pkg::NUM_W-1]};
    assign w_ge   = (w_part >= {1'b0, r_den});
    assign w_diff = w_part - {1'b0, r_den};
    assign n_rem  = w_ge ? w_diff[msgseg_pkg::DEN_W-1:0] : w_part[msgseg_pkg::DEN_W-1:0];
    assign w_last = (r_step == msgseg_pkg::STEP_W'(msgseg_pkg::NUM_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[msgseg_pkg::NUM_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[msgseg_pkg::NUM_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

>>> src/msgseg_emit.sv
// ============================================================================
// msgseg_emit: packet descriptor emitter
// Holds one message's run and presents one descriptor at a time, stepping the
// offset and the countdown on each output transfer.
// ============================================================================
module msgseg_emit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  msgseg_pkg::t_load                   i_load,
    input  logic [msgseg_pkg::HOST_W-1:0]       i_host,
    output logic                                o_free,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [msgseg_pkg::HOST_W-1:0]       o_source_host,
    output logic [msgseg_pkg::MSG_W-1:0]        o_message_number,
    output logic [msgseg_pkg::REMAIN_W-1:0]     o_packets_remaining,
    output logic                                o_first_flag,
    output logic [msgseg_pkg::LEN_W-1:0]        o_payload_offset,
    output logic [msgseg_pkg::PAY_W-1:0]        o_payload_bytes,
    output logic [msgseg_pkg::PKT_W-1:0]        o_packet_bytes,
    output logic                                o_last_packet
);

    logic                              r_valid;
    logic                              r_first;
    logic [msgseg_pkg::LEN_W-1:0]      r_len;
    logic [msgseg_pkg::LEN_W-1:0]      r_offset;
    logic [msgseg_pkg::CAP_W-1:0]      r_chunk;
    logic [msgseg_pkg::LEFT_W-1:0]     r_left;
    logic [msgseg_pkg::MSG_W-1:0]      r_msg;

    logic                              w_last;
    logic                              w_xfer;
    logic [msgseg_pkg::LEN_W-1:0]      w_pay;
    logic [msgseg_pkg::LEN_W:0]        w_pkt;

    assign w_last = (r_left == '0);
    assign w_xfer = r_valid && i_ready;
    // The final packet carries whatever the earlier ones left over.
    assign w_pay  = w_last ? (r_len - r_offset) : msgseg_pkg::LEN_W'(r_chunk);
    assign w_pkt  = {1'b0, w_pay} + (msgseg_pkg::LEN_W + 1)'(msgseg_pkg::HEADER_BYTES);
    assign o_free = !r_valid || (i_ready && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load.valid) begin
            r_valid <= 1'b1;
        end else if (w_xfer && w_last) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.valid) begin
            r_len    <= i_load.len;
            r_chunk  <= i_load.chunk;
            r_left   <= i_load.left;
            r_msg    <= i_load.msg;
            r_offset <= '0;
            r_first  <= 1'b1;
        end else if (w_xfer && !w_last) begin
            r_left   <= r_left - 1'b1;
            r_offset <= r_offset + msgseg_pkg::LEN_W'(r_chunk);
            r_first  <= 1'b0;
        end
    end

    assign o_valid             = r_valid;
    assign o_source_host       = i_host;
    assign o_message_number    = r_msg;
    assign o_packets_remaining = msgseg_pkg::REMAIN_W'(r_left);
    assign o_first_flag        = r_first;
    assign o_payload_offset    = r_offset;
    assign o_payload_bytes     = w_pay[msgseg_pkg::PAY_W-1:0];
    assign o_packet_bytes      = w_pkt[msgseg_pkg::PKT_W-1:0];
    assign o_last_packet       = w_last;

endmodule

>>> src/message_segmenter.sv
// ============================================================================
// message_segmenter: splits a message length into packet descriptors
// Two bit-serial divisions find the packet count and the per-packet payload,
// then the emitter hands out one descriptor per output transfer.
// ============================================================================
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-------------------------------------
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_host_id
//  input    | i_in_valid  / o_in_ready   | i_message_length
//  output   | o_out_valid / i_out_ready  | o_source_host .. o_last_packet
//
// After a message transfers in, the shared serial divider finds the packet count
// (one quotient bit per cycle); the controller then checks the count and
// starts the payload division, sees that division done and loads the emitter
// once it is free. The emitter then presents one descriptor per cycle while
// the sink is ready. An empty or oversized message returns the block to idle
// after the count check, ready for the next input transfer.
// The next message is taken in once the emitter holds the current run, so its
// divisions overlap the previous run's descriptors.
// Synchronous active-low reset clears the state, the message counter and
// host_id, and both ready outputs stay low while it is held; output stalls
// simply hold the current descriptor.
//
module message_segmenter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [msgseg_pkg::HOST_W-1:0]       i_cfg_host_id,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [msgseg_pkg::LEN_W-1:0]        i_message_length,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [msgseg_pkg::HOST_W-1:0]       o_source_host,
    output logic [msgseg_pkg::MSG_W-1:0]        o_message_number,
    output logic [msgseg_pkg::REMAIN_W-1:0]     o_packets_remaining,
    output logic                                o_first_flag,
    output logic [msgseg_pkg::LEN_W-1:0]        o_payload_offset,
    output logic [msgseg_pkg::PAY_W-1:0]        o_payload_bytes,
    output logic [msgseg_pkg::PKT_W-1:0]        o_packet_bytes,
    output logic                                o_last_packet
);

    msgseg_pkg::t_state                 r_state;
    msgseg_pkg::t_state                 n_state;
    logic [msgseg_pkg::HOST_W-1:0]      r_host_id;
    logic [msgseg_pkg::MSG_W-1:0]       r_msg_ctr;
    logic [msgseg_pkg::LEN_W-1:0]       r_len;
    logic [msgseg_pkg::CNT_W-1:0]       r_count;

    msgseg_pkg::t_div_req               w_div_req;
    msgseg_pkg::t_div_rsp               w_div_rsp;
    msgseg_pkg::t_load                  w_load;
    logic                               w_em_free;
    logic                               w_in_xfer;
    logic                               w_cnt_ok;
    logic [msgseg_pkg::CNT_W-1:0]       w_cnt;

    // Configuration is accepted whenever reset is released; the user must send
    // it only while the block idles, which the block itself does not enforce.
    assign o_cfg_ready = i_rst_n;
    assign w_in_xfer   = i_in_valid && o_in_ready;

    // A zero count (empty message) or one beyond the packet limit drops the
    // message; the message id still advances.
    assign w_cnt    = w_div_rsp.quo[msgseg_pkg::CNT_W-1:0];
    assign w_cnt_ok = (w_div_rsp.quo != '0) &&
                      (w_div_rsp.quo <= msgseg_pkg::NUM_W'(msgseg_pkg::MAX_PACKETS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= msgseg_pkg::ST_IDLE;
            r_host_id <= '0;
            r_msg_ctr <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_host_id <= i_cfg_host_id;
            end
            if (w_in_xfer) begin
                r_msg_ctr <= r_msg_ctr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_len <= i_message_length;
        end
        if (r_state == msgseg_pkg::ST_COUNT && w_div_rsp.done) begin
            r_count <= w_cnt;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            msgseg_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = msgseg_pkg::ST_COUNT;
                end
            end
            msgseg_pkg::ST_COUNT: begin
                if (w_div_rsp.done) begin
                    n_state = w_cnt_ok ? msgseg_pkg::ST_CHUNK : msgseg_pkg::ST_IDLE;
                end
            end
            msgseg_pkg::ST_CHUNK: begin
                if (w_div_rsp.done) begin
                    n_state = msgseg_pkg::ST_LOAD;
                end
            end
            msgseg_pkg::ST_LOAD: begin
                if (w_em_free) begin
                    n_state = msgseg_pkg::ST_IDLE;
                end
            end
            default: n_state = msgseg_pkg::ST_IDLE;
        endcase
    end

    // Output logic: divider requests, the emitter load and input ready.
    always_comb begin
        o_in_ready      = 1'b0;
        w_div_req.start = 1'b0;
        w_div_req.num   = '0;
        w_div_req.den   = '0;
        w_load.valid    = 1'b0;
        w_load.len      = r_len;
        w_load.chunk    = w_div_rsp.quo[msgseg_pkg::CAP_W-1:0];
        w_load.left     = msgseg_pkg::LEFT_W'(r_count - 1'b1);
        w_load.msg      = r_msg_ctr;
        unique case (r_state)
            msgseg_pkg::ST_IDLE: begin
                // Count = ceil(length / capacity).
                o_in_ready      = i_rst_n;
                w_div_req.start = i_in_valid;
                w_div_req.num   = msgseg_pkg::NUM_W'(i_message_length) +
                                  msgseg_pkg::NUM_W'(msgseg_pkg::CAPACITY - 1);
                w_div_req.den   = msgseg_pkg::DEN_W'(msgseg_pkg::CAPACITY);
            end
            msgseg_pkg::ST_COUNT: begin
                // Payload = ceil(length / count).
                w_div_req.start = w_div_rsp.done && w_cnt_ok;
                w_div_req.num   = msgseg_pkg::NUM_W'(r_len) + msgseg_pkg::NUM_W'(w_cnt) -
                                  msgseg_pkg::NUM_W'(1);
                w_div_req.den   = msgseg_pkg::DEN_W'(w_cnt);
            end
            msgseg_pkg::ST_CHUNK: begin
            end
            msgseg_pkg::ST_LOAD: begin
                // The divider holds the payload quotient until the next start.
                w_load.valid = w_em_free;
            end
            default: begin
            end
        endcase
    end

    msgseg_serdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    msgseg_emit u_emit (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_load              (w_load),
        .i_host              (r_host_id),
        .o_free              (w_em_free),
        .o_valid             (o_out_valid),
        .i_ready             (i_out_ready),
        .o_source_host       (o_source_host),
        .o_message_number    (o_message_number),
        .o_packets_remaining (o_packets_remaining),
        .o_first_flag        (o_first_flag),
        .o_payload_offset    (o_payload_offset),
        .o_payload_bytes     (o_payload_bytes),
        .o_packet_bytes      (o_packet_bytes),
        .o_last_packet       (o_last_packet)
    );

endmodule

>>> src/msgseg_checker.sv
// ============================================================================
// msgseg_checker: port-level checks of the message segmenter
// Watches the output channel for held descriptors and consistent run markers.
// ============================================================================
module msgseg_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [msgseg_pkg::MSG_W-1:0]        o_message_number,
    input logic [msgseg_pkg::REMAIN_W-1:0]     o_packets_remaining,
    input logic                                o_first_flag,
    input logic [msgseg_pkg::LEN_W-1:0]        o_payload_offset,
    input logic [msgseg_pkg::PAY_W-1:0]        o_payload_bytes,
    input logic                                o_last_packet
);

    // A stalled descriptor holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_message_number) &&
        $stable(o_payload_offset) && $stable(o_payload_bytes))
        else $error("stalled descriptor changed");

    // Within a run the next descriptor follows at once.
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_packet |=>
        o_out_valid && !o_first_flag && $stable(o_message_number))
        else $error("run broken before its last descriptor");

    // The first descriptor starts at offset zero.
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_first_flag |-> o_payload_offset == '0)
        else $error("first descriptor at nonzero offset");

    // The last marker agrees with the countdown.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_packet == (o_packets_remaining == '0)))
        else $error("last marker and countdown disagree");

endmodule

bind message_segmenter msgseg_checker u_msgseg_checker (.*);

>>> sim/testbench.sv
// ============================================================================
// testbench: self-checking bench for the message segmenter
// Drives message lengths and host id writes, predicts every packet descriptor
// of each message, and checks each output transfer against the oldest one due.
// ============================================================================
module testbench;

    // Cycles of reset at the start of the run.
    localparam int RESET_CYCLES   = 7;
    // Quiet cycles after the last descriptor, long enough for a message that
    // yields no descriptors (one serial division and the count check).
    localparam int SETTLE_CYCLES  = 100;
    // Length of the long receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES    = 300;
    // Cycles without any transfer before the run is declared hung. This covers
    // the hold-off, the settle pause and the longest idle gaps with margin.
    localparam int WATCHDOG_LIMIT = 3000;
    // Mismatch reports are capped so a badly broken block cannot flood the log.
    localparam int MAX_REPORTS    = 100;

    // One packet descriptor as the output channel carries it.
    typedef struct packed {
        logic [msgseg_pkg::HOST_W-1:0]   source_host;
        logic [msgseg_pkg::MSG_W-1:0]    message_number;
        logic [msgseg_pkg::REMAIN_W-1:0] packets_remaining;
        logic                            first_flag;
        logic [msgseg_pkg::LEN_W-1:0]    payload_offset;
        logic [msgseg_pkg::PAY_W-1:0]    payload_bytes;
        logic [msgseg_pkg::PKT_W-1:0]    packet_bytes;
        logic                            last_packet;
    } t_descriptor;

    // Clock, reset and block inputs, all at known values from time zero.
    logic                            i_clk            = 1'b0;
    logic                            i_rst_n          = 1'b0;
    logic                            i_cfg_valid      = 1'b0;
    logic [msgseg_pkg::HOST_W-1:0]   i_cfg_host_id    = '0;
    logic                            i_in_valid       = 1'b0;
    logic [msgseg_pkg::LEN_W-1:0]    i_message_length = '0;
    logic                            i_out_ready      = 1'b0;

    // Block outputs.
    logic                            o_cfg_ready;
    logic                            o_in_ready;
    logic                            o_out_valid;
    logic [msgseg_pkg::HOST_W-1:0]   o_source_host;
    logic [msgseg_pkg::MSG_W-1:0]    o_message_number;
    logic [msgseg_pkg::REMAIN_W-1:0] o_packets_remaining;
    logic                            o_first_flag;
    logic [msgseg_pkg::LEN_W-1:0]    o_payload_offset;
    logic [msgseg_pkg::PAY_W-1:0]    o_payload_bytes;
    logic [msgseg_pkg::PKT_W-1:0]    o_packet_bytes;
    logic                            o_last_packet;

    // Lengths waiting to be offered, and descriptors predicted but not yet seen.
    logic [msgseg_pkg::LEN_W-1:0] length_queue[$];
    t_descriptor                  descriptors_due[$];

    // Shadow of the block's state as the predictor sees it.
    logic [msgseg_pkg::HOST_W-1:0] host_shadow = '0;
    logic [msgseg_pkg::MSG_W-1:0]  message_count = '0;

    // Idling controls, written by the stimulus process only.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req       = 0;

    // Receiver-side hold-off bookkeeping, owned by the receiver process.
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    logic        in_taken    = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned error_count = 0;

    // Directed lengths: the extremes of the field, the capacity boundaries,
    // a zero-length message, messages that need too many packets, and
    // alternating bit patterns so every length bit toggles.
    logic [msgseg_pkg::LEN_W-1:0] directed_lengths[] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd1015, 16'd1016, 16'd1017,
        16'd2032, 16'd2033, 16'd3049, 16'h00FF, 16'h5555, 16'hAAAA,
        16'd32768, 16'd65023, 16'd65024, 16'd65025, 16'hFFFF, 16'd0, 16'd7
    };

    message_segmenter i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_host_id       (i_cfg_host_id),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_message_length    (i_message_length),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_source_host       (o_source_host),
        .o_message_number    (o_message_number),
        .o_packets_remaining (o_packets_remaining),
        .o_first_flag        (o_first_flag),
        .o_payload_offset    (o_payload_offset),
        .o_payload_bytes     (o_payload_bytes),
        .o_packet_bytes      (o_packet_bytes),
        .o_last_packet       (o_last_packet)
    );

    // Two time units per period: high for one, low for one.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predicts the descriptors of one accepted message. The message number
    // advances on every message, even one that is empty or too long to send.
    // The packet count is the exact ceiling of length over capacity; all but
    // the last packet carry the ceiling of length over count, and the last one
    // carries whatever is left.
    function automatic void segment_message(input logic [msgseg_pkg::LEN_W-1:0] length);
        int unsigned count;
        int unsigned chunk;
        int unsigned pay;
        int unsigned offset;
        int unsigned idx;
        t_descriptor d;
        message_count = message_count + 1'b1;
        if (length == 0)
            return;
        count = (int'(length) + msgseg_pkg::CAPACITY - 1) / msgseg_pkg::CAPACITY;
        if (count > msgseg_pkg::MAX_PACKETS)
            return;
        chunk  = (int'(length) + count - 1) / count;
        offset = 0;
        for (idx = 0; idx < count; idx++) begin
            pay = (idx == count - 1) ? int'(length) - offset : chunk;
            d.source_host       = host_shadow;
            d.message_number    = message_count;
            d.packets_remaining = msgseg_pkg::REMAIN_W'(count - idx - 1);
            d.first_flag        = (idx == 0);
            d.payload_offset    = msgseg_pkg::LEN_W'(offset);
            d.payload_bytes     = msgseg_pkg::PAY_W'(pay);
            d.packet_bytes      = msgseg_pkg::PKT_W'(pay + msgseg_pkg::HEADER_BYTES);
            d.last_packet       = (idx == count - 1);
            descriptors_due.insert(descriptors_due.size(), d);
            offset = offset + pay;
        end
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    // Random message length. Most messages are short so runs stay cheap; a
    // few sit on capacity multiples, a few are near the top of the range, and
    // some are empty or too long to fit in the packet limit.
    function automatic logic [msgseg_pkg::LEN_W-1:0] pick_length();
        int unsigned roll;
        int unsigned k;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        else if (roll < 13)
            return msgseg_pkg::LEN_W'($urandom_range(65535, 65025));
        else if (roll < 17)
            return msgseg_pkg::LEN_W'($urandom_range(65024, 50000));
        else if (roll < 30) begin
            k = $urandom_range(64, 1);
            return msgseg_pkg::LEN_W'(k * msgseg_pkg::CAPACITY + $urandom_range(2) - 1);
        end else if (roll < 50)
            return msgseg_pkg::LEN_W'($urandom_range(16000, 1));
        else
            return msgseg_pkg::LEN_W'($urandom_range(3000, 1));
    endfunction

    // Input driver: a new length is presented at the falling edge only when
    // the channel is empty or its item transferred at the last rising edge.
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (length_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid       <= 1'b1;
                i_message_length <= length_queue[0];
            end else begin
                i_in_valid       <= 1'b0;
                i_message_length <= msgseg_pkg::LEN_W'($urandom());
            end
        end
    end

    // Output receiver: random stalls, plus a long hold-off whenever the
    // stimulus asks for one. The hold-off is counted here in cycles.
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: checks each output transfer against the oldest prediction,
    // predicts on each input transfer, and keeps the watchdog.
    always @(posedge i_clk) begin : monitor
        t_descriptor want;
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (descriptors_due.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $error("descriptor transfer with none expected, message %0d",
                               o_message_number);
                end else begin
                    want = descriptors_due.pop_front();
                    check_field("source_host", want.source_host, o_source_host);
                    check_field("message_number", want.message_number, o_message_number);
                    check_field("packets_remaining", want.packets_remaining,
                                o_packets_remaining);
                    check_field("first_flag", want.first_flag, o_first_flag);
                    check_field("payload_offset", want.payload_offset, o_payload_offset);
                    check_field("payload_bytes", want.payload_bytes, o_payload_bytes);
                    check_field("packet_bytes", want.packet_bytes, o_packet_bytes);
                    check_field("last_packet", want.last_packet, o_last_packet);
                end
            end
            if (i_in_valid && o_in_ready) begin
                segment_message(i_message_length);
                void'(length_queue.pop_front());
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Waits until every queued length has transferred and every predicted
    // descriptor has arrived, then lets the block settle so that a trailing
    // empty or dropped message is finished too.
    task automatic wait_idle();
        while (length_queue.size() != 0 || descriptors_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes host_id over the configuration channel; only called while idle.
    task automatic write_host(input logic [msgseg_pkg::HOST_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid   <= 1'b1;
        i_cfg_host_id <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        host_shadow = value;
        @(negedge i_clk);
        i_cfg_valid   <= 1'b0;
        i_cfg_host_id <= msgseg_pkg::HOST_W'($urandom());
    endtask

    // Queues a batch of random lengths under the given idling mix.
    task automatic run_random(input int unsigned count, input int unsigned send_pct,
                              input int unsigned recv_pct);
        int unsigned n;
        @(posedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (n = 0; n < count; n++)
            length_queue.insert(length_queue.size(), pick_length());
    endtask

    initial begin : stimulus
        int unsigned n;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed messages run first with host_id still at its reset value.
        @(posedge i_clk);
        foreach (directed_lengths[k])
            length_queue.insert(length_queue.size(), directed_lengths[k]);
        wait_idle();

        // Random phases, one host_id setting each, all ones among them.
        write_host('1);
        run_random(20, 0, 0);
        wait_idle();
        write_host(msgseg_pkg::HOST_W'($urandom()));
        run_random(20, 65, 0);
        wait_idle();
        write_host(32'h8000_0001);
        run_random(20, 0, 65);
        wait_idle();
        write_host(msgseg_pkg::HOST_W'($urandom()));
        run_random(25, 29, 29);
        wait_idle();

        // Back-pressure: the sink holds off for a long stretch while a steady
        // stream of multi-packet messages is offered, so the block fills up
        // and stops taking input transfers.
        write_host('0);
        @(posedge i_clk);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (n = 0; n < 12; n++)
            length_queue.insert(length_queue.size(),
                                msgseg_pkg::LEN_W'($urandom_range(6000, 1100)));
        hold_req = hold_req + 1;
        wait_idle();

        // A run of short and empty messages under idling on both sides.
        write_host(msgseg_pkg::HOST_W'($urandom()));
        @(posedge i_clk);
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        for (n = 0; n < 33; n++)
            length_queue.insert(length_queue.size(),
                                ($urandom_range(1) == 0) ? '0
                                : msgseg_pkg::LEN_W'($urandom_range(40, 1)));
        wait_idle();

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
